### rtl/pbcl_pkg.sv
// ----------------------------------------------------------------------------
// pbcl_pkg
// Shared types and constants of the power buffer current limiter.
// ----------------------------------------------------------------------------
package pbcl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // pipelined restoring divider geometry
  localparam int DIV_STAGES = 18;
  localparam int QUO_W      = DIV_STAGES;
  localparam int DSR_W      = 20;
  localparam int DVD_W      = 34;

  localparam logic [CFG_IDX_W-1:0] REG_BUF_FULL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECTIFY        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_BUDGET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_THRESHOLD = 3'd4;

  localparam logic [7:0]  RST_BUF_FULL       = 8'd60;
  localparam logic [15:0] RST_OUTPUT_MAX     = 16'd16000;
  localparam logic [15:0] RST_RECTIFY        = 16'd0;
  localparam logic [15:0] RST_OFFLINE_BUDGET = 16'd1600;
  localparam logic [7:0]  RST_CUBE_THRESHOLD = 8'd18;

  typedef struct packed {
    logic signed [15:0] cmd_left_front;
    logic signed [15:0] cmd_right_front;
    logic signed [15:0] cmd_left_back;
    logic signed [15:0] cmd_right_back;
    logic               link_online;
    logic [9:0]         power_buffer;
    logic signed [15:0] target_front;
    logic signed [15:0] measured_front;
    logic signed [15:0] target_right;
    logic signed [15:0] measured_right;
    logic signed [15:0] target_turn;
    logic signed [15:0] measured_turn;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_left_front;
    logic signed [15:0] out_right_front;
    logic signed [15:0] out_left_back;
    logic signed [15:0] out_right_back;
    logic [15:0]        budget;
    logic               scaled;
  } out_t;

endpackage

### rtl/pbcl_div.sv
// ----------------------------------------------------------------------------
// pbcl_div
// Pipelined restoring divider, one quotient bit per stage. The dividend must
// be below divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module pbcl_div import pbcl_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic [DSR_W-1:0] rem [DIV_STAGES];
  logic [QUO_W-1:0] low [DIV_STAGES];
  logic [QUO_W-1:0] quo [DIV_STAGES];
  logic [DSR_W-1:0] dsr [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DSR_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DSR_W-1:0] dsr_in;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_in = DSR_W'(dividend[DVD_W-1:QUO_W]);
      assign low_in = dividend[QUO_W-1:0];
      assign quo_in = '0;
      assign dsr_in = divisor;
    end else begin : g_next
      assign rem_in = rem[g-1];
      assign low_in = low[g-1];
      assign quo_in = quo[g-1];
      assign dsr_in = dsr[g-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        low[g] <= {low_in[QUO_W-2:0], 1'b0};
        quo[g] <= {quo_in[QUO_W-2:0], ge};
        dsr[g] <= dsr_in;
      end
    end
  end

  assign quotient = quo[DIV_STAGES-1];

endmodule

### rtl/power_buffer_current_limiter.sv
// ----------------------------------------------------------------------------
// power_buffer_current_limiter
// Limits four mecanum wheel currents to a budget set by the power buffer.
//
// Input channel in_valid/in_ready/in_data carries one control tick per
// transfer; output channel out_valid/out_ready/out_data returns one result
// per tick, in order. Configuration is written through cfg_we/cfg_index/
// cfg_data, one register per cycle; the user must do so only while the
// block is idle, which the block itself does not enforce.
// An input transfer reaches the output through input decode, an 18 stage
// divider for the buffer ratio (the command correction runs alongside),
// three budget stages, one |a| * budget stage, an 18 stage divider per
// wheel for the budget/sum scaling, and the output register.
// Throughput is one tick per cycle unless the receiver stalls. The whole
// pipeline advances together; when the receiver stalls with a result
// waiting, it holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults; there is no
// clearing pass and the block accepts input in the first cycle after reset.
// ----------------------------------------------------------------------------
module power_buffer_current_limiter import pbcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ST_SIDE   = 4;
  localparam int ST_K      = 1 + DIV_STAGES;
  localparam int ST_BUDGET = ST_K + 3;
  localparam int ST_MUL    = ST_K + 4;
  localparam int ST_Q      = ST_MUL + DIV_STAGES;
  localparam int ST_OUT    = ST_Q + 1;
  localparam int MAG_W     = QUO_W;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic [DSR_W-1:0]      total;
    logic                  online;
    logic                  ltc;
  } side_t;

  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [3:0]            neg;
    logic [DSR_W-1:0]      total;
    logic [15:0]           budget;
    logic                  gt;
  } scale_t;

  logic [7:0]  buf_full;
  logic [15:0] output_max;
  logic [15:0] rectify;
  logic [15:0] offline_budget;
  logic [7:0]  cube_threshold;

  logic              adv;
  logic [ST_OUT:1]   vld;

  function automatic logic signed [2:0] err_sign(logic signed [15:0] t,
                                                  logic signed [15:0] m);
    logic [16:0] d;
    d = {t[15], t} - {m[15], m};
    if (d == '0) return 3'sd0;
    else if (d[16]) return -3'sd1;
    else return 3'sd1;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full       <= RST_BUF_FULL;
      output_max     <= RST_OUTPUT_MAX;
      rectify        <= RST_RECTIFY;
      offline_budget <= RST_OFFLINE_BUDGET;
      cube_threshold <= RST_CUBE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUF_FULL:       buf_full       <= cfg_data[7:0];
        REG_OUTPUT_MAX:     output_max     <= cfg_data;
        REG_RECTIFY:        rectify        <= cfg_data;
        REG_OFFLINE_BUDGET: offline_budget <= cfg_data;
        REG_CUBE_THRESHOLD: cube_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv      = !vld[ST_OUT] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_OUT-1:1], in_valid};
    end
  end

  // stage 1: decode
  logic [7:0]         bm_eff;
  logic [7:0]         b_clamp;
  logic signed [2:0]  ef, er, et;

  logic signed [15:0] cmd1 [4];
  logic signed [2:0]  sum1 [4];
  logic [7:0]         b1;
  logic [7:0]         bm1;
  logic               online1;
  logic               ltc1;

  always_comb begin
    bm_eff  = (buf_full == '0) ? 8'd1 : buf_full;
    b_clamp = (in_data.power_buffer > {2'b00, bm_eff}) ? bm_eff
                                                       : in_data.power_buffer[7:0];
    ef = err_sign(in_data.target_front, in_data.measured_front);
    er = err_sign(in_data.target_right, in_data.measured_right);
    et = err_sign(in_data.target_turn, in_data.measured_turn);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1[0] <= in_data.cmd_left_front;
      cmd1[1] <= in_data.cmd_right_front;
      cmd1[2] <= in_data.cmd_left_back;
      cmd1[3] <= in_data.cmd_right_back;
      sum1[0] <= ef + er + et;
      sum1[1] <= -ef + er + et;
      sum1[2] <= ef - er + et;
      sum1[3] <= -ef - er + et;
      b1      <= b_clamp;
      bm1     <= bm_eff;
      online1 <= in_data.link_online;
      ltc1    <= b_clamp < cube_threshold;
    end
  end

  // stage 2: |cmd| * coefficient
  logic signed [15:0] cmd2 [4];
  logic signed [2:0]  sum2 [4];
  logic [31:0]        prod2 [4];
  logic               online2;
  logic               ltc2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        cmd2[i]  <= cmd1[i];
        sum2[i]  <= sum1[i];
        prod2[i] <= 32'(cmd1[i][15] ? 16'(~cmd1[i] + 16'd1) : cmd1[i]) * 32'(rectify);
      end
      online2 <= online1;
      ltc2    <= ltc1;
    end
  end

  // stage 3: corrected command, truncated toward zero
  logic signed [35:0] num3 [4];
  logic [35:0]        anum3 [4];
  logic [3:0][MAG_W-1:0] mag3;
  logic [3:0]         neg3;
  logic               online3;
  logic               ltc3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num3[i]  = $signed({{4{cmd2[i][15]}}, cmd2[i], 16'b0})
               + $signed({{33{sum2[i][2]}}, sum2[i]}) * $signed({4'b0, prod2[i]});
      anum3[i] = num3[i][35] ? 36'(-num3[i]) : 36'(num3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mag3[i] <= anum3[i][COEF_BITS+MAG_W-1:COEF_BITS];
        neg3[i] <= num3[i][35];
      end
      online3 <= online2;
      ltc3    <= ltc2;
    end
  end

  // stage 4 onward: side data delay line
  side_t sd [ST_SIDE:ST_BUDGET];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[ST_SIDE].mag    <= mag3;
      sd[ST_SIDE].neg    <= neg3;
      sd[ST_SIDE].total  <= DSR_W'(mag3[0]) + DSR_W'(mag3[1])
                          + DSR_W'(mag3[2]) + DSR_W'(mag3[3]);
      sd[ST_SIDE].online <= online3;
      sd[ST_SIDE].ltc    <= ltc3;
      for (int j = ST_SIDE + 1; j <= ST_BUDGET; j++) sd[j] <= sd[j-1];
    end
  end

  // buffer ratio k = b * 2^FRAC_BITS / bm
  logic [QUO_W-1:0] k19;

  pbcl_div u_div_ratio (
    .clk      (clk),
    .en       (adv),
    .dividend (DVD_W'({b1, FRAC_BITS'(0)})),
    .divisor  (DSR_W'(bm1)),
    .quotient (k19)
  );

  // budget stages
  logic [2*QUO_W-1:0] kk;
  logic [2*QUO_W-1:0] kkk;
  logic [QUO_W+15:0]  kbo;
  logic [QUO_W-1:0]   k2_20;
  logic [QUO_W-1:0]   k_20;
  logic [QUO_W-1:0]   kp_21;
  logic [15:0]        budget22;

  always_comb begin
    kk  = (2*QUO_W)'(k19) * (2*QUO_W)'(k19);
    kkk = (2*QUO_W)'(k2_20) * (2*QUO_W)'(k_20);
    kbo = (QUO_W+16)'(kp_21) * (QUO_W+16)'(output_max);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_20    <= kk[FRAC_BITS+QUO_W-1:FRAC_BITS];
      k_20     <= k19;
      kp_21    <= sd[ST_K+1].ltc ? kkk[FRAC_BITS+QUO_W-1:FRAC_BITS] : k2_20;
      budget22 <= sd[ST_K+2].online ? kbo[FRAC_BITS+15:FRAC_BITS] : offline_budget;
    end
  end

  // stage 23: |a| * budget and compare
  logic [DVD_W-1:0] prod23 [4];
  scale_t           sc [ST_MUL:ST_Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod23[i] <= DVD_W'(sd[ST_BUDGET].mag[i]) * DVD_W'(budget22);
      end
      sc[ST_MUL].mag    <= sd[ST_BUDGET].mag;
      sc[ST_MUL].neg    <= sd[ST_BUDGET].neg;
      sc[ST_MUL].total  <= sd[ST_BUDGET].total;
      sc[ST_MUL].budget <= budget22;
      sc[ST_MUL].gt     <= sd[ST_BUDGET].total > DSR_W'(budget22);
      for (int j = ST_MUL + 1; j <= ST_Q; j++) sc[j] <= sc[j-1];
    end
  end

  logic [QUO_W-1:0] q41 [4];

  for (genvar w = 0; w < 4; w++) begin : g_scale
    pbcl_div u_div_scale (
      .clk      (clk),
      .en       (adv),
      .dividend (prod23[w]),
      .divisor  (sc[ST_MUL].total),
      .quotient (q41[w])
    );
  end

  // output stage: select, sign and saturate
  logic [MAG_W-1:0]  m_sel [4];
  logic signed [15:0] cur [4];
  out_t              out_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_sel[i] = sc[ST_Q].gt ? q41[i] : sc[ST_Q].mag[i];
      if (sc[ST_Q].neg[i]) begin
        cur[i] = (m_sel[i] > MAG_W'(32768)) ? 16'sh8000 : 16'(16'd0 - m_sel[i][15:0]);
      end else begin
        cur[i] = (m_sel[i] > MAG_W'(32767)) ? 16'sh7FFF : m_sel[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q.out_left_front  <= cur[0];
      out_q.out_right_front <= cur[1];
      out_q.out_left_back   <= cur[2];
      out_q.out_right_back  <= cur[3];
      out_q.budget          <= sc[ST_Q].budget;
      out_q.scaled          <= sc[ST_Q].gt;
    end
  end

  assign out_valid = vld[ST_OUT];
  assign out_data  = out_q;

endmodule

### rtl/pbcl_checker.sv
// ----------------------------------------------------------------------------
// pbcl_checker
// Port-level checks of the power buffer current limiter.
// ----------------------------------------------------------------------------
module pbcl_checker import pbcl_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  logic [16:0] a0, a1, a2, a3;
  logic [18:0] abs_sum;

  always_comb begin
    a0 = out_data.out_left_front[15]  ? 17'(-$signed({1'b1, out_data.out_left_front}))
                                      : {1'b0, out_data.out_left_front};
    a1 = out_data.out_right_front[15] ? 17'(-$signed({1'b1, out_data.out_right_front}))
                                      : {1'b0, out_data.out_right_front};
    a2 = out_data.out_left_back[15]   ? 17'(-$signed({1'b1, out_data.out_left_back}))
                                      : {1'b0, out_data.out_left_back};
    a3 = out_data.out_right_back[15]  ? 17'(-$signed({1'b1, out_data.out_right_back}))
                                      : {1'b0, out_data.out_right_back};
    abs_sum = 19'(a0) + 19'(a1) + 19'(a2) + 19'(a3);
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_budget: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> abs_sum <= 19'(out_data.budget))
    else $error("limited currents exceed budget");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind power_buffer_current_limiter pbcl_checker u_pbcl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/tb_power_buffer_current_limiter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_buffer_current_limiter
// Drives control ticks through the current limiter and compares every result
// against an in-bench predictor of the budget law, the straight-line
// correction and the budget/sum scaling. Directed table first, then random
// ticks over several register settings, with random idling and stalls.
// ----------------------------------------------------------------------------
module tb_power_buffer_current_limiter;
  import pbcl_pkg::*;

  localparam int LATENCY = 42;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  power_buffer_current_limiter DUT (.*);

  // predictor copy of the registers
  logic [7:0] buf_max_q;
  logic [15:0] out_max_q, rectify_q, offline_q;
  logic [7:0] cube_thr_q;

  out_t limited_q[$];
  int errors = 0;
  int stall_mode = 0;  // 0 random, 1 hold off, 2 always ready
  bit quiet_in = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint sgn(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic out_t limit_currents(input in_t t);
    out_t r;
    longint bm, b, k, k2, k3, kp, budget, total;
    longint cmd[4], adj[4], s[4];
    longint ef, er, et, num, m;
    cmd[0] = longint'(t.cmd_left_front);
    cmd[1] = longint'(t.cmd_right_front);
    cmd[2] = longint'(t.cmd_left_back);
    cmd[3] = longint'(t.cmd_right_back);
    if (!t.link_online) begin
      budget = longint'(offline_q);
    end else begin
      bm = (buf_max_q == 0) ? 1 : longint'(buf_max_q);
      b = (longint'(t.power_buffer) > bm) ? bm : longint'(t.power_buffer);
      k = (b << FRAC_BITS) / bm;
      k2 = (k * k) >>> FRAC_BITS;
      k3 = (k2 * k) >>> FRAC_BITS;
      kp = (b < longint'(cube_thr_q)) ? k3 : k2;
      budget = (kp * longint'(out_max_q)) >>> FRAC_BITS;
    end
    ef = sgn(longint'(t.target_front) - longint'(t.measured_front));
    er = sgn(longint'(t.target_right) - longint'(t.measured_right));
    et = sgn(longint'(t.target_turn) - longint'(t.measured_turn));
    s[0] = ef + er + et;
    s[1] = -ef + er + et;
    s[2] = ef - er + et;
    s[3] = -ef - er + et;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      num = cmd[i] * 65536 + mag(cmd[i]) * s[i] * longint'(rectify_q);
      adj[i] = (num < 0) ? -(mag(num) >>> 16) : (num >>> 16);
      total += mag(adj[i]);
    end
    r.scaled = total > budget;
    if (r.scaled)
      for (int i = 0; i < 4; i++) begin
        m = mag(adj[i]) * budget / total;
        adj[i] = adj[i] < 0 ? -m : m;
      end
    r.out_left_front = 16'(sat(adj[0]));
    r.out_right_front = 16'(sat(adj[1]));
    r.out_left_back = 16'(sat(adj[2]));
    r.out_right_back = 16'(sat(adj[3]));
    r.budget = budget[15:0];
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BUF_FULL: buf_max_q = val[7:0];
      REG_OUTPUT_MAX: out_max_q = val;
      REG_RECTIFY: rectify_q = val;
      REG_OFFLINE_BUDGET: offline_q = val;
      REG_CUBE_THRESHOLD: cube_thr_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (limited_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // one transfer; the predictor runs at acceptance; valid stays up for the
  // next transfer unless the sender idles
  task automatic send(input in_t t);
    while (!quiet_in && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    limited_q.push_back(limit_currents(t));
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rnd_tick();
    in_t t;
    t.cmd_left_front = rnd16();
    t.cmd_right_front = rnd16();
    t.cmd_left_back = rnd16();
    t.cmd_right_back = rnd16();
    t.link_online = ($urandom_range(9) != 0);
    t.power_buffer = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(300));
    t.target_front = rnd16();
    t.measured_front = ($urandom_range(3) == 0) ? t.target_front : rnd16();
    t.target_right = rnd16();
    t.measured_right = ($urandom_range(3) == 0) ? t.target_right : rnd16();
    t.target_turn = rnd16();
    t.measured_turn = ($urandom_range(3) == 0) ? t.target_turn : rnd16();
    return t;
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (stall_mode == 1) out_ready <= 1'b0;
    else if (stall_mode == 2) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && out_ready) begin
      if (limited_q.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        w = limited_q.pop_front();
        if (out_data.out_left_front !== w.out_left_front)
          report("out_left_front", out_data.out_left_front, w.out_left_front);
        if (out_data.out_right_front !== w.out_right_front)
          report("out_right_front", out_data.out_right_front, w.out_right_front);
        if (out_data.out_left_back !== w.out_left_back)
          report("out_left_back", out_data.out_left_back, w.out_left_back);
        if (out_data.out_right_back !== w.out_right_back)
          report("out_right_back", out_data.out_right_back, w.out_right_back);
        if (out_data.budget !== w.budget) report("budget", out_data.budget, w.budget);
        if (out_data.scaled !== w.scaled) report("scaled", out_data.scaled, w.scaled);
      end
    end
  end

  typedef struct {
    in_t tick;
    bit known;
    logic [15:0] budget;
  } row_t;

  function automatic in_t mk(input logic signed [15:0] c, input logic on,
                             input logic [9:0] pb, input logic signed [15:0] tf,
                             input logic signed [15:0] mf);
    in_t t;
    t = '0;
    t.cmd_left_front = c;
    t.cmd_right_front = -c;
    t.cmd_left_back = c;
    t.cmd_right_back = -c;
    t.link_online = on;
    t.power_buffer = pb;
    t.target_front = tf;
    t.measured_front = mf;
    return t;
  endfunction

  initial begin
    row_t rows[$];
    in_t t;
    buf_max_q = RST_BUF_FULL;
    out_max_q = RST_OUTPUT_MAX;
    rectify_q = RST_RECTIFY;
    offline_q = RST_OFFLINE_BUDGET;
    cube_thr_q = RST_CUBE_THRESHOLD;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: offline budget 1600, full buffer gives output_max
    rows.push_back('{mk(16'sd1000, 1'b0, 10'd0, 16'sd0, 16'sd0), 1, 16'd1600});
    rows.push_back('{mk(16'sd0, 1'b1, 10'd60, 16'sd0, 16'sd0), 1, 16'd16000});
    rows.push_back('{mk(16'sh7fff, 1'b1, 10'd1023, 16'sh7fff, 16'sh8000), 1, 16'd16000});
    rows.push_back('{mk(16'sh8000, 1'b1, 10'd0, 16'sh8000, 16'sh7fff), 1, 16'd0});
    rows.push_back('{mk(16'sd100, 1'b1, 10'd17, 16'sd5, 16'sd1), 0, 16'd0});
    rows.push_back('{mk(16'sd100, 1'b1, 10'd18, 16'sd1, 16'sd5), 0, 16'd0});
    rows.push_back('{mk(16'sd3000, 1'b1, 10'd30, 16'sd0, 16'sd0), 0, 16'd0});
    rows.push_back('{mk(-16'sd3999, 1'b0, 10'd1023, 16'sd0, 16'sd0), 1, 16'd1600});
    t = mk(16'sh7fff, 1'b1, 10'd60, 16'sd1, 16'sd0);
    t.target_right = 16'sd1;
    t.target_turn = 16'sd1;
    rows.push_back('{t, 0, 16'd0});
    foreach (rows[i]) begin
      send(rows[i].tick);
      if (rows[i].known && limited_q[$].budget !== rows[i].budget)
        report("table budget", limited_q[$].budget, rows[i].budget);
    end
    drain();

    // gain and saturation
    write_reg(REG_RECTIFY, 16'hffff);
    write_reg(REG_OUTPUT_MAX, 16'hffff);
    write_reg(REG_OFFLINE_BUDGET, 16'hffff);
    send(t);
    t.link_online = 1'b0;
    send(t);
    t.cmd_left_front = 16'sh8000;
    t.target_front = -16'sd1;
    send(t);
    drain();
    write_reg(REG_BUF_FULL, 16'd0);
    write_reg(REG_CUBE_THRESHOLD, 16'd255);
    write_reg(REG_UNUSED, 16'h1234);
    send(mk(16'sd500, 1'b1, 10'd0, 16'sd0, 16'sd0));
    send(mk(16'sd500, 1'b1, 10'd1, 16'sd0, 16'sd0));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BUF_FULL, 16'd255); write_reg(REG_CUBE_THRESHOLD, 16'd0);
          write_reg(REG_OUTPUT_MAX, 16'd0); write_reg(REG_RECTIFY, 16'd0);
          write_reg(REG_OFFLINE_BUDGET, 16'd0);
        end
        1: begin
          write_reg(REG_BUF_FULL, 16'd1); write_reg(REG_OUTPUT_MAX, 16'hffff);
          write_reg(REG_RECTIFY, 16'h8000);
        end
        default: begin
          write_reg(REG_BUF_FULL, 16'($urandom_range(1, 255)));
          write_reg(REG_OUTPUT_MAX, 16'($urandom));
          write_reg(REG_RECTIFY, 16'($urandom));
          write_reg(REG_OFFLINE_BUDGET, 16'($urandom));
          write_reg(REG_CUBE_THRESHOLD, 16'($urandom_range(255)));
        end
      endcase
      quiet_in = (ph == 3);
      if (ph == 3) stall_mode = 2;
      if (ph == 2) begin
        fork
          begin
            stall_mode = 1;
            repeat (150) @(negedge clk);
            stall_mode = 0;
          end
        join_none
      end
      for (int n = 0; n < 88; n++) begin
        send(rnd_tick());
        if (n == 40) begin
          in_valid <= 1'b0;
          while (limited_q.size() != 0) @(negedge clk);
        end
      end
      stall_mode = 0;
      drain();
    end

    if (errors == 0) $display("power_buffer_current_limiter verification clean");
    else $display("power_buffer_current_limiter verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("power_buffer_current_limiter verification failed");
    $finish;
  end

endmodule
